>>> hw/rtl/sdspi_pkg.sv
package sdspi_pkg;

   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned BUF_AW = $clog2(BLOCK_BYTES);

   typedef enum logic [4:0] {
      PH_IDLE, PH_CLK, PH_FRAME, PH_POLL, PH_LONG, PH_TAIL, PH_TOKEN, PH_RDATA,
      PH_RCRC, PH_WGAP, PH_WTOKEN, PH_WDATA, PH_DRESP, PH_BUSY
   } phase_type;

   typedef enum logic [1:0] {
      KIND_INIT, KIND_RAW, KIND_READ, KIND_WRITE
   } kind_type;

   localparam logic [2:0] OP_INIT     = 3'd0;
   localparam logic [2:0] OP_RAW      = 3'd1;
   localparam logic [2:0] OP_READ     = 3'd2;
   localparam logic [2:0] OP_WRITE    = 3'd3;
   localparam logic [2:0] OP_LOAD     = 3'd4;
   localparam logic [2:0] OP_EXCHANGE = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_R1    = 3'd1;
   localparam logic [2:0] ST_NO_TOKEN  = 3'd2;
   localparam logic [2:0] ST_BAD_FMT   = 3'd3;
   localparam logic [2:0] ST_CRC_REJ   = 3'd4;
   localparam logic [2:0] ST_WR_ERR    = 3'd5;
   localparam logic [2:0] ST_OTHER_REJ = 3'd6;

   localparam logic [2:0] DRESP_OK  = 3'b010;
   localparam logic [2:0] DRESP_CRC = 3'b101;
   localparam logic [2:0] DRESP_WR  = 3'b110;

   localparam logic [7:0] IDLE_BYTE   = 8'hFF;
   localparam logic [7:0] START_TOKEN = 8'hFE;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [5:0]  command_index;
      logic [31:0] command_argument;
      logic [7:0]  crc_byte;
      logic        long_response;
      logic [31:0] block_number;
      logic [8:0]  load_offset;
      logic [7:0]  load_value;
      logic [7:0]  received_byte;
   } req_payload_type;

   typedef struct packed {
      logic        send_valid;
      logic [7:0]  send_byte;
      logic        select_active;
      logic        read_valid;
      logic [7:0]  read_data;
      logic [8:0]  read_offset;
      logic        finished;
      logic [2:0]  status;
      logic [7:0]  response_r1;
      logic [31:0] ocr_value;
      logic        high_capacity;
   } rsp_payload_type;

   typedef struct packed {
      logic              wr_en;
      logic [BUF_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [BUF_AW-1:0] rd_addr;
   } wbuf_ctrl_type;

endpackage

>>> hw/rtl/sdspi_if.sv
interface sdspi_req_if import sdspi_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdspi_rsp_if import sdspi_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/sdspi_wbuf.sv
module sdspi_wbuf import sdspi_pkg::*; (
   input  logic          clock,
   input  wbuf_ctrl_type ctrl,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [BLOCK_BYTES];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_data <= mem[ctrl.rd_addr];
   end

endmodule

>>> hw/rtl/sd_card_spi_host_top.sv
// spi-mode sd card host, one byte exchange per transaction
// req_ch carries operation starts (init, raw command, read, write), write
// buffer loads and exchange transactions holding the byte the card returned
// for the previous send. every request transaction yields exactly one
// response transaction on rsp_ch naming the next byte to send, chip select,
// any block data byte read, completion and status.
// the response is registered and becomes valid in the cycle after acceptance.
// throughput: one transaction per cycle while rsp_ch keeps taking responses;
// the write buffer is a memory with a registered read port, addressed ahead at
// the index the next exchange will need, so write data bytes go out back to back.
// the response register is freed as it is taken, so a new request is taken
// in the same cycle as a waiting response; when rsp_ch stalls, req_ch stalls.
// csr_write_en/csr_write_data set the retry limit (reset 10, zero acts as one)
// and must only be written while idle.
// reset (synchronous) returns to idle with select released, r1 reads 0xff
// and standard capacity assumed; the write buffer is not cleared.
module sd_card_spi_host_top import sdspi_pkg::*; #(
   parameter int unsigned IDLE_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   sdspi_req_if.sink   req_ch,
   sdspi_rsp_if.source rsp_ch,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data
);

   phase_type       phase_ff, phase_in;
   kind_type        kind_ff, kind_in;
   logic [2:0]      step_ff, step_in;
   logic [9:0]      bc_ff, bc_in;
   logic [7:0]      poll_ff, poll_in;
   logic [7:0]      acmd_ff, acmd_in;
   logic [47:0]     frame_ff, frame_in;
   logic [7:0]      r1_ff, r1_in;
   logic [31:0]     ocr_ff, ocr_in;
   logic            hc_ff, hc_in;
   logic            long_ff, long_in;
   logic            pv_ff, pv_in;
   logic [7:0]      pb_ff, pb_in;
   logic            ps_ff, ps_in;
   logic [7:0]      retry_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   wbuf_ctrl_type   wb_ctrl;
   logic [7:0]      wb_rdata;

   logic            accept;
   logic [7:0]      lim;
   logic [9:0]      bc_inc;
   logic [7:0]      rx;
   logic [31:0]     addr;
   logic            o_rvalid, o_fin;
   logic [7:0]      o_rdata;
   logic [8:0]      o_roff;
   logic [2:0]      o_status;
   logic            go;
   logic [5:0]      go_idx;
   logic [31:0]     go_arg;
   logic [7:0]      go_crc;
   logic            go_long;
   logic [47:0]     long_shift;
   req_payload_type rq;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rq           = req_ch.payload;
   assign rx           = rq.received_byte;
   assign lim          = (retry_ff == 8'd0) ? 8'd1 : retry_ff;
   assign bc_inc       = bc_ff + 10'd1;
   assign addr         = hc_ff ? rq.block_number : {rq.block_number[31-BUF_AW:0], {BUF_AW{1'b0}}};
   assign long_shift   = {16'd0, frame_ff[23:0], rx};

   function automatic logic [7:0] frame_byte(input logic [47:0] f, input logic [2:0] k);
      logic [7:0] b;
      unique case (k)
         3'd0:    b = f[47:40];
         3'd1:    b = f[39:32];
         3'd2:    b = f[31:24];
         3'd3:    b = f[23:16];
         3'd4:    b = f[15:8];
         default: b = f[7:0];
      endcase
      return b;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      step_in  = step_ff;
      bc_in    = bc_ff;
      poll_in  = poll_ff;
      acmd_in  = acmd_ff;
      frame_in = frame_ff;
      r1_in    = r1_ff;
      ocr_in   = ocr_ff;
      hc_in    = hc_ff;
      long_in  = long_ff;
      pv_in    = pv_ff;
      pb_in    = pb_ff;
      ps_in    = ps_ff;
      o_rvalid = 1'b0;
      o_rdata  = 8'd0;
      o_roff   = 9'd0;
      o_fin    = 1'b0;
      o_status = ST_OK;
      go       = 1'b0;
      go_idx   = 6'd0;
      go_arg   = 32'd0;
      go_crc   = 8'd0;
      go_long  = 1'b0;
      wb_ctrl.wr_en   = 1'b0;
      wb_ctrl.wr_addr = rq.load_offset[BUF_AW-1:0];
      wb_ctrl.wr_data = rq.load_value;

      if (accept) begin
         if (phase_ff == PH_IDLE) begin
            unique case (rq.opcode)
               OP_INIT: begin
                  kind_in = KIND_INIT; phase_in = PH_CLK; bc_in = 10'd0;
                  pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b0;
               end
               OP_RAW: begin
                  kind_in = KIND_RAW; go = 1'b1; go_idx = rq.command_index;
                  go_arg = rq.command_argument; go_crc = rq.crc_byte;
                  go_long = rq.long_response;
               end
               OP_READ: begin
                  kind_in = KIND_READ; go = 1'b1; go_idx = 6'd17; go_arg = addr;
                  go_crc = 8'h01;
               end
               OP_WRITE: begin
                  kind_in = KIND_WRITE; go = 1'b1; go_idx = 6'd24; go_arg = addr;
                  go_crc = 8'h01;
               end
               OP_LOAD: wb_ctrl.wr_en = 1'b1;
               default: ;
            endcase
         end else if (rq.opcode == OP_EXCHANGE) begin
            unique case (phase_ff)
               PH_CLK: begin
                  bc_in = bc_inc;
                  if (bc_inc < 10'(IDLE_BYTES)) begin
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b0;
                  end else begin
                     step_in = 3'd0; go = 1'b1; go_idx = 6'd0; go_crc = 8'h95;
                  end
               end
               PH_FRAME: begin
                  bc_in = bc_inc;
                  if (bc_inc < 10'd6) begin
                     pv_in = 1'b1; pb_in = frame_byte(frame_ff, bc_inc[2:0]); ps_in = 1'b1;
                  end else begin
                     phase_in = PH_POLL; poll_in = 8'd1;
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  end
               end
               PH_POLL: begin
                  if (rx != IDLE_BYTE || poll_ff >= lim) begin
                     r1_in = rx;
                     if (kind_ff == KIND_INIT || kind_ff == KIND_RAW) begin
                        if (rx != IDLE_BYTE && long_ff) begin
                           phase_in = PH_LONG; bc_in = 10'd0;
                           pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                        end else begin
                           phase_in = PH_TAIL;
                           pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b0;
                        end
                     end else if (rx != 8'h00) begin
                        phase_in = PH_IDLE; pv_in = 1'b0; pb_in = 8'd0; ps_in = 1'b0;
                        o_fin = 1'b1; o_status = ST_BAD_R1;
                     end else if (kind_ff == KIND_READ) begin
                        phase_in = PH_TOKEN; poll_in = 8'd1;
                        pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                     end else begin
                        phase_in = PH_WGAP;
                        pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                     end
                  end else begin
                     poll_in = poll_ff + 8'd1;
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  end
               end
               PH_LONG: begin
                  frame_in = long_shift;
                  bc_in = bc_inc;
                  if (bc_inc < 10'd4) begin
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  end else begin
                     ocr_in = long_shift[31:0]; phase_in = PH_TAIL;
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b0;
                  end
               end
               PH_TAIL: begin
                  if (kind_ff == KIND_INIT) begin
                     unique case (step_ff)
                        3'd0: begin
                           step_in = 3'd1; go = 1'b1; go_idx = 6'd8;
                           go_arg = 32'h0000_01AA; go_crc = 8'h87; go_long = 1'b1;
                        end
                        3'd1: begin
                           step_in = 3'd2; go = 1'b1; go_idx = 6'd58;
                           go_crc = 8'h01; go_long = 1'b1;
                        end
                        3'd2: begin
                           acmd_in = 8'd0; step_in = 3'd3; go = 1'b1; go_idx = 6'd55;
                           go_crc = 8'h65;
                        end
                        3'd3: begin
                           step_in = 3'd4; go = 1'b1; go_idx = 6'd41; go_crc = 8'hE5;
                        end
                        3'd4: begin
                           acmd_in = acmd_ff + 8'd1;
                           go = 1'b1;
                           if (r1_ff == 8'h00 || acmd_in >= lim) begin
                              step_in = 3'd5; go_idx = 6'd58; go_crc = 8'h01;
                              go_long = 1'b1;
                           end else begin
                              step_in = 3'd3; go_idx = 6'd55; go_crc = 8'h65;
                           end
                        end
                        3'd5: begin
                           hc_in = ocr_ff[30]; step_in = 3'd6; go = 1'b1;
                           go_idx = 6'd16; go_arg = 32'(BLOCK_BYTES); go_crc = 8'h01;
                        end
                        default: begin
                           phase_in = PH_IDLE; pv_in = 1'b0; pb_in = 8'd0; ps_in = 1'b0;
                           o_fin = 1'b1; o_status = ST_OK;
                        end
                     endcase
                  end else begin
                     phase_in = PH_IDLE; pv_in = 1'b0; pb_in = 8'd0; ps_in = 1'b0;
                     o_fin = 1'b1; o_status = ST_OK;
                  end
               end
               PH_TOKEN: begin
                  if (rx == START_TOKEN) begin
                     phase_in = PH_RDATA; bc_in = 10'd0;
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  end else if (poll_ff >= lim) begin
                     phase_in = PH_IDLE; pv_in = 1'b0; pb_in = 8'd0; ps_in = 1'b0;
                     o_fin = 1'b1; o_status = ST_NO_TOKEN;
                  end else begin
                     poll_in = poll_ff + 8'd1;
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  end
               end
               PH_RDATA: begin
                  o_rvalid = 1'b1; o_rdata = rx; o_roff = bc_ff[8:0];
                  bc_in = bc_inc;
                  pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  if (bc_inc >= 10'(BLOCK_BYTES)) begin
                     phase_in = PH_RCRC; bc_in = 10'd0;
                  end
               end
               PH_RCRC: begin
                  bc_in = bc_inc;
                  if (bc_inc < 10'd2) begin
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  end else begin
                     phase_in = PH_TAIL;
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b0;
                  end
               end
               PH_WGAP: begin
                  phase_in = PH_WTOKEN;
                  pv_in = 1'b1; pb_in = START_TOKEN; ps_in = 1'b1;
               end
               PH_WTOKEN: begin
                  phase_in = PH_WDATA; bc_in = 10'd0;
                  pv_in = 1'b1; pb_in = wb_rdata; ps_in = 1'b1;
               end
               PH_WDATA: begin
                  bc_in = bc_inc;
                  if (bc_inc < 10'(BLOCK_BYTES)) begin
                     pv_in = 1'b1; pb_in = wb_rdata; ps_in = 1'b1;
                  end else begin
                     phase_in = PH_DRESP; poll_in = 8'd1;
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  end
               end
               PH_DRESP: begin
                  if (rx != IDLE_BYTE || poll_ff >= lim) begin
                     if (rx[4] || !rx[0]) begin
                        phase_in = PH_IDLE; pv_in = 1'b0; pb_in = 8'd0; ps_in = 1'b0;
                        o_fin = 1'b1; o_status = ST_BAD_FMT;
                     end else if (rx[3:1] == DRESP_OK) begin
                        phase_in = PH_BUSY;
                        pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                     end else begin
                        phase_in = PH_IDLE; pv_in = 1'b0; pb_in = 8'd0; ps_in = 1'b0;
                        o_fin = 1'b1;
                        o_status = (rx[3:1] == DRESP_CRC) ? ST_CRC_REJ :
                                   (rx[3:1] == DRESP_WR)  ? ST_WR_ERR : ST_OTHER_REJ;
                     end
                  end else begin
                     poll_in = poll_ff + 8'd1;
                     pv_in = 1'b1; pb_in = IDLE_BYTE; ps_in = 1'b1;
                  end
               end
               PH_BUSY: begin
                  pv_in = 1'b1; pb_in = IDLE_BYTE;
                  if (rx == 8'h00) begin
                     ps_in = 1'b1;
                  end else begin
                     phase_in = PH_TAIL; ps_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end

         if (go) begin
            frame_in = {2'b01, go_idx, go_arg, go_crc};
            long_in  = go_long;
            bc_in    = 10'd0;
            phase_in = PH_FRAME;
            pv_in    = 1'b1;
            pb_in    = {2'b01, go_idx};
            ps_in    = 1'b1;
         end
      end

      // fetch the byte the next exchange will send
      wb_ctrl.rd_addr = (phase_in == PH_WDATA) ? (bc_in[BUF_AW-1:0] + BUF_AW'(1))
                                               : BUF_AW'(0);

      rsp_in.send_valid    = pv_in;
      rsp_in.send_byte     = pv_in ? pb_in : 8'd0;
      rsp_in.select_active = ps_in;
      rsp_in.read_valid    = o_rvalid;
      rsp_in.read_data     = o_rdata;
      rsp_in.read_offset   = o_roff;
      rsp_in.finished      = o_fin;
      rsp_in.status        = o_status;
      rsp_in.response_r1   = r1_in;
      rsp_in.ocr_value     = ocr_in;
      rsp_in.high_capacity = hc_in;
   end

   sdspi_wbuf u_wbuf (
      .clock   (clock),
      .ctrl    (wb_ctrl),
      .rd_data (wb_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         kind_ff      <= KIND_RAW;
         step_ff      <= 3'd0;
         bc_ff        <= 10'd0;
         poll_ff      <= 8'd0;
         acmd_ff      <= 8'd0;
         frame_ff     <= 48'd0;
         r1_ff        <= 8'hFF;
         ocr_ff       <= 32'd0;
         hc_ff        <= 1'b0;
         long_ff      <= 1'b0;
         pv_ff        <= 1'b0;
         pb_ff        <= 8'd0;
         ps_ff        <= 1'b0;
         retry_ff     <= 8'd10;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         step_ff  <= step_in;
         bc_ff    <= bc_in;
         poll_ff  <= poll_in;
         acmd_ff  <= acmd_in;
         frame_ff <= frame_in;
         r1_ff    <= r1_in;
         ocr_ff   <= ocr_in;
         hc_ff    <= hc_in;
         long_ff  <= long_in;
         pv_ff    <= pv_in;
         pb_ff    <= pb_in;
         ps_ff    <= ps_in;
         if (csr_write_en) begin
            retry_ff <= csr_write_data;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

endmodule

>>> bench/sdspi_checker.sv
`timescale 1ns / 1ps

module sdspi_checker import sdspi_pkg::*; #(
   parameter int unsigned IDLE_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   sdspi_req_if        req_ch,
   sdspi_rsp_if        rsp_ch,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data,
   output int          mismatch_count,
   output int          outstanding
);

   rsp_payload_type expected_rsp_q[$];

   logic [7:0]  retry_limit;
   phase_type   ph;
   kind_type    kind;
   int unsigned init_step;
   logic [9:0]  byte_cnt;
   logic [7:0]  poll_cnt;
   logic [7:0]  acmd_cnt;
   logic [47:0] frame;
   logic [7:0]  r1_val;
   logic [31:0] ocr_val;
   logic        block_addr;
   logic        want_long;
   logic [7:0]  wbuf [BLOCK_BYTES];
   logic        pend_v, pend_sel;
   logic [7:0]  pend_b;
   logic        o_rvalid, o_fin;
   logic [7:0]  o_rdata;
   logic [8:0]  o_roff;
   logic [2:0]  o_status;

   assign outstanding = expected_rsp_q.size();

   function automatic int unsigned cur_limit();
      return (retry_limit == 8'd0) ? 1 : int'(retry_limit);
   endfunction

   function automatic logic [7:0] frame_byte(int unsigned k);
      return frame[47 - 8*k -: 8];
   endfunction

   function automatic void emit(logic [7:0] b, logic sel);
      pend_v = 1'b1;
      pend_b = b;
      pend_sel = sel;
   endfunction

   function automatic void end_op(logic [2:0] st);
      ph = PH_IDLE;
      pend_v = 1'b0;
      pend_b = 8'd0;
      pend_sel = 1'b0;
      o_fin = 1'b1;
      o_status = st;
   endfunction

   function automatic void start_cmd(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc,
                                     logic lng);
      frame = {2'b01, idx, arg, crc};
      want_long = lng;
      byte_cnt = '0;
      ph = PH_FRAME;
      emit(frame_byte(0), 1'b1);
   endfunction

   function automatic void init_next();
      case (init_step)
         0: begin
            init_step = 1; start_cmd(6'd8, 32'h1AA, 8'h87, 1'b1);
         end
         1: begin
            init_step = 2; start_cmd(6'd58, 32'd0, 8'h01, 1'b1);
         end
         2: begin
            acmd_cnt = '0; init_step = 3; start_cmd(6'd55, 32'd0, 8'h65, 1'b0);
         end
         3: begin
            init_step = 4; start_cmd(6'd41, 32'd0, 8'hE5, 1'b0);
         end
         4: begin
            acmd_cnt = acmd_cnt + 8'd1;
            if (r1_val == 8'h00 || acmd_cnt >= cur_limit()) begin
               init_step = 5; start_cmd(6'd58, 32'd0, 8'h01, 1'b1);
            end else begin
               init_step = 3; start_cmd(6'd55, 32'd0, 8'h65, 1'b0);
            end
         end
         5: begin
            block_addr = ocr_val[30];
            init_step = 6; start_cmd(6'd16, BLOCK_BYTES, 8'h01, 1'b0);
         end
         default: end_op(ST_OK);
      endcase
   endfunction

   function automatic void r1_taken();
      if (kind == KIND_INIT || kind == KIND_RAW) begin
         if (r1_val != 8'hFF && want_long) begin
            ph = PH_LONG; byte_cnt = '0; emit(IDLE_BYTE, 1'b1);
         end else begin
            ph = PH_TAIL; emit(IDLE_BYTE, 1'b0);
         end
      end else if (r1_val != 8'h00) begin
         end_op(ST_BAD_R1);
      end else if (kind == KIND_READ) begin
         ph = PH_TOKEN; poll_cnt = 8'd1; emit(IDLE_BYTE, 1'b1);
      end else begin
         ph = PH_WGAP; emit(IDLE_BYTE, 1'b1);
      end
   endfunction

   function automatic void exchange(logic [7:0] rx);
      logic [2:0] code;
      case (ph)
         PH_CLK: begin
            byte_cnt++;
            if (byte_cnt < IDLE_BYTES) emit(IDLE_BYTE, 1'b0);
            else begin
               init_step = 0; start_cmd(6'd0, 32'd0, 8'h95, 1'b0);
            end
         end
         PH_FRAME: begin
            byte_cnt++;
            if (byte_cnt < 6) emit(frame_byte(byte_cnt), 1'b1);
            else begin
               ph = PH_POLL; poll_cnt = 8'd1; emit(IDLE_BYTE, 1'b1);
            end
         end
         PH_POLL: begin
            if (rx != 8'hFF || poll_cnt >= cur_limit()) begin
               r1_val = rx; r1_taken();
            end else begin
               poll_cnt++; emit(IDLE_BYTE, 1'b1);
            end
         end
         PH_LONG: begin
            frame = {16'd0, frame[23:0], rx};
            byte_cnt++;
            if (byte_cnt < 4) emit(IDLE_BYTE, 1'b1);
            else begin
               ocr_val = frame[31:0]; ph = PH_TAIL; emit(IDLE_BYTE, 1'b0);
            end
         end
         PH_TAIL: begin
            if (kind == KIND_INIT) init_next();
            else end_op(ST_OK);
         end
         PH_TOKEN: begin
            if (rx == START_TOKEN) begin
               ph = PH_RDATA; byte_cnt = '0; emit(IDLE_BYTE, 1'b1);
            end else if (poll_cnt >= cur_limit()) end_op(ST_NO_TOKEN);
            else begin
               poll_cnt++; emit(IDLE_BYTE, 1'b1);
            end
         end
         PH_RDATA: begin
            o_rvalid = 1'b1; o_rdata = rx; o_roff = byte_cnt[8:0];
            byte_cnt++;
            if (byte_cnt < BLOCK_BYTES) emit(IDLE_BYTE, 1'b1);
            else begin
               ph = PH_RCRC; byte_cnt = '0; emit(IDLE_BYTE, 1'b1);
            end
         end
         PH_RCRC: begin
            byte_cnt++;
            if (byte_cnt < 2) emit(IDLE_BYTE, 1'b1);
            else begin
               ph = PH_TAIL; emit(IDLE_BYTE, 1'b0);
            end
         end
         PH_WGAP: begin
            ph = PH_WTOKEN; emit(START_TOKEN, 1'b1);
         end
         PH_WTOKEN: begin
            ph = PH_WDATA; byte_cnt = '0; emit(wbuf[0], 1'b1);
         end
         PH_WDATA: begin
            byte_cnt++;
            if (byte_cnt < BLOCK_BYTES) emit(wbuf[byte_cnt[8:0]], 1'b1);
            else begin
               ph = PH_DRESP; poll_cnt = 8'd1; emit(IDLE_BYTE, 1'b1);
            end
         end
         PH_DRESP: begin
            if (rx != 8'hFF || poll_cnt >= cur_limit()) begin
               code = rx[3:1];
               // format is bad when bit 4 is set or bit 0 is clear
               if (rx[4] || !rx[0]) end_op(ST_BAD_FMT);
               else if (code == DRESP_OK) begin
                  ph = PH_BUSY; emit(IDLE_BYTE, 1'b1);
               end else if (code == DRESP_CRC) end_op(ST_CRC_REJ);
               else if (code == DRESP_WR) end_op(ST_WR_ERR);
               else end_op(ST_OTHER_REJ);
            end else begin
               poll_cnt++; emit(IDLE_BYTE, 1'b1);
            end
         end
         PH_BUSY: begin
            if (rx == 8'h00) emit(IDLE_BYTE, 1'b1);
            else begin
               ph = PH_TAIL; emit(IDLE_BYTE, 1'b0);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_payload_type host_step(req_payload_type t);
      rsp_payload_type r;
      logic [31:0] addr;
      addr = block_addr ? t.block_number : (t.block_number << 9);
      o_rvalid = 1'b0; o_rdata = '0; o_roff = '0; o_fin = 1'b0; o_status = ST_OK;
      if (ph == PH_IDLE) begin
         case (t.opcode)
            OP_INIT: begin
               kind = KIND_INIT; ph = PH_CLK; byte_cnt = '0; emit(IDLE_BYTE, 1'b0);
            end
            OP_RAW: begin
               kind = KIND_RAW;
               start_cmd(t.command_index, t.command_argument, t.crc_byte, t.long_response);
            end
            OP_READ: begin
               kind = KIND_READ; start_cmd(6'd17, addr, 8'h01, 1'b0);
            end
            OP_WRITE: begin
               kind = KIND_WRITE; start_cmd(6'd24, addr, 8'h01, 1'b0);
            end
            OP_LOAD: wbuf[t.load_offset] = t.load_value;
            default: ;
         endcase
      end else if (t.opcode == OP_EXCHANGE) begin
         exchange(t.received_byte);
      end
      r.send_valid    = pend_v;
      r.send_byte     = pend_v ? pend_b : 8'd0;
      r.select_active = pend_sel;
      r.read_valid    = o_rvalid;
      r.read_data     = o_rdata;
      r.read_offset   = o_roff;
      r.finished      = o_fin;
      r.status        = o_status;
      r.response_r1   = r1_val;
      r.ocr_value     = ocr_val;
      r.high_capacity = block_addr;
      return r;
   endfunction

   task automatic report(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want, got;
      if (reset) begin
         retry_limit = 8'd10;
         ph = PH_IDLE; kind = KIND_RAW; init_step = 0;
         byte_cnt = '0; poll_cnt = '0; acmd_cnt = '0; frame = '0;
         r1_val = 8'hFF; ocr_val = '0; block_addr = 1'b0; want_long = 1'b0;
         pend_v = 1'b0; pend_b = '0; pend_sel = 1'b0;
         expected_rsp_q.delete();
      end else begin
         // a response taken now belongs to an earlier transaction
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response transaction, expected none, actual 0x%0h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.send_valid !== want.send_valid)
                  report("send_valid", want.send_valid, got.send_valid);
               if (got.send_byte !== want.send_byte)
                  report("send_byte", want.send_byte, got.send_byte);
               if (got.select_active !== want.select_active)
                  report("select_active", want.select_active, got.select_active);
               if (got.read_valid !== want.read_valid)
                  report("read_valid", want.read_valid, got.read_valid);
               if (got.read_data !== want.read_data)
                  report("read_data", want.read_data, got.read_data);
               if (got.read_offset !== want.read_offset)
                  report("read_offset", want.read_offset, got.read_offset);
               if (got.finished !== want.finished)
                  report("finished", want.finished, got.finished);
               if (got.status !== want.status)
                  report("status", want.status, got.status);
               if (got.response_r1 !== want.response_r1)
                  report("response_r1", want.response_r1, got.response_r1);
               if (got.ocr_value !== want.ocr_value)
                  report("ocr_value", want.ocr_value, got.ocr_value);
               if (got.high_capacity !== want.high_capacity)
                  report("high_capacity", want.high_capacity, got.high_capacity);
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_rsp_q.push_back(host_step(req_ch.payload));
         if (csr_write_en)
            retry_limit = csr_write_data;
      end
   end

   initial mismatch_count = 0;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import sdspi_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [7:0] csr_write_data = 8'd0;
   int mismatch_count;
   int outstanding;
   int unsigned cycle = 0;
   int unsigned stall_cycles = 0;
   int unsigned req_taken = 0;
   int unsigned rsp_taken = 0;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;
   logic last_send_valid = 1'b0;

   req_payload_type stim_q[$];

   sdspi_req_if req_ch ();
   sdspi_rsp_if rsp_ch ();

   sd_card_spi_host_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   sdspi_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // no idling on either side in this window
   function automatic bit quiet_window();
      return cycle >= 4000 && cycle < 7000;
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (stim_q.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 35)) begin
            req_ch.payload <= stim_q.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && cycle > 9000) begin
         // long hold-off so the block backs up and stalls its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet_window() || $urandom_range(0, 99) >= 35;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) req_taken <= req_taken + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken <= rsp_taken + 1;
            last_send_valid <= rsp_ch.payload.send_valid;
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   function automatic req_payload_type rand_item();
      req_payload_type t;
      t.opcode           = 3'($urandom);
      t.command_index    = 6'($urandom);
      t.command_argument = $urandom;
      t.crc_byte         = 8'($urandom);
      t.long_response    = 1'($urandom);
      t.block_number     = $urandom;
      t.load_offset      = 9'($urandom);
      t.load_value       = 8'($urandom);
      t.received_byte    = 8'($urandom);
      return t;
   endfunction

   task automatic push_op(logic [2:0] op);
      req_payload_type t;
      t = rand_item();
      t.opcode = op;
      stim_q.push_back(t);
   endtask

   task automatic push_rx(logic [7:0] rx);
      req_payload_type t;
      t = rand_item();
      t.opcode = OP_EXCHANGE;
      t.received_byte = rx;
      stim_q.push_back(t);
   endtask

   task automatic push_load(logic [8:0] off, logic [7:0] val);
      req_payload_type t;
      t = rand_item();
      t.opcode = OP_LOAD;
      t.load_offset = off;
      t.load_value = val;
      stim_q.push_back(t);
   endtask

   // frame bytes, a few idle polls, then the r1 byte
   task automatic card_r1(logic [7:0] r1);
      int n;
      n = $urandom_range(0, 2);
      repeat (6) push_rx(8'hFF);
      repeat (n) push_rx(8'hFF);
      push_rx(r1);
   endtask

   task automatic card_cmd(logic [7:0] r1, bit lng, logic [31:0] payload);
      card_r1(r1);
      if (lng && r1 != 8'hFF)
         for (int i = 3; i >= 0; i--) push_rx(payload[8*i +: 8]);
      push_rx(8'hFF);
   endtask

   task automatic raw_txn(logic [5:0] idx, logic [31:0] arg, bit lng, logic [7:0] r1);
      req_payload_type t;
      t = rand_item();
      t.opcode = OP_RAW;
      t.command_index = idx;
      t.command_argument = arg;
      t.long_response = lng;
      stim_q.push_back(t);
      card_cmd(r1, lng, $urandom);
   endtask

   task automatic init_txn(int unsigned busy_rounds, bit hc);
      logic [31:0] ocr;
      ocr = $urandom;
      ocr[30] = hc;
      push_op(OP_INIT);
      repeat (10) push_rx(8'hFF);
      card_cmd(8'h01, 1'b0, 0);
      card_cmd(8'h01, 1'b1, 32'h1AA);
      card_cmd(8'h01, 1'b1, ocr);
      for (int i = 0; i <= busy_rounds; i++) begin
         card_cmd(8'h01, 1'b0, 0);
         card_cmd((i == busy_rounds) ? 8'h00 : 8'h01, 1'b0, 0);
      end
      card_cmd(8'h00, 1'b1, ocr);
      card_cmd(8'h00, 1'b0, 0);
   endtask

   // kind 0 good, 1 bad r1, 2 no start token
   task automatic read_txn(int kind);
      int n;
      n = $urandom_range(0, 3);
      push_op(OP_READ);
      card_r1(kind == 1 ? 8'h04 : 8'h00);
      if (kind == 2) begin
         repeat (12) push_rx(8'h00);
      end else if (kind == 0) begin
         repeat (n) push_rx(8'hFF);
         push_rx(START_TOKEN);
         repeat (BLOCK_BYTES) push_rx(8'($urandom));
         repeat (3) push_rx(8'hFF);
      end
   endtask

   task automatic write_txn(bit good_r1, logic [7:0] dresp);
      int n;
      n = $urandom_range(0, 2);
      push_op(OP_WRITE);
      card_r1(good_r1 ? 8'h00 : 8'h09);
      if (good_r1) begin
         repeat (2 + BLOCK_BYTES) push_rx(8'hFF);
         repeat (n) push_rx(8'hFF);
         push_rx(dresp);
         repeat ($urandom_range(0, 3)) push_rx(8'h00);
         push_rx(8'hFF);
         push_rx(8'hFF);
      end
   endtask

   function automatic logic [7:0] rand_dresp();
      int p;
      p = $urandom_range(0, 9);
      if (p < 6) return 8'hE5;
      if (p == 6) return 8'h0B;
      if (p == 7) return 8'h0D;
      return 8'($urandom);
   endfunction

   task automatic random_op();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) raw_txn(6'($urandom), $urandom, 1'($urandom), 8'($urandom_range(0, 3)));
      else if (pick < 40) read_txn($urandom_range(0, 2));
      else if (pick < 45) write_txn(($urandom_range(0, 2) == 0), rand_dresp());
      else if (pick < 52) init_txn($urandom_range(0, 2), 1'($urandom));
      else if (pick < 75) push_load(9'($urandom), 8'($urandom));
      else if (pick < 88) push_rx(8'($urandom));
      else stim_q.push_back(rand_item());
   endtask

   task automatic wait_drained();
      while (stim_q.size() > 0 || req_ch.valid || rsp_taken != req_taken) @(posedge clock);
   endtask

   // finish any operation left open by a broken sequence
   task automatic settle_idle();
      wait_drained();
      while (last_send_valid) begin
         push_rx(8'h05);
         wait_drained();
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limit(logic [7:0] v);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [7:0] limits [4];
      int unsigned target;
      limits[0] = 8'd1;
      limits[1] = 8'd255;
      limits[2] = 8'd0;
      limits[3] = 8'($urandom_range(2, 254));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < BLOCK_BYTES; i++) push_load(9'(i), 8'($urandom));

      // directed part at the reset retry limit
      push_rx(8'h00);
      push_op(3'd6);
      push_op(3'd7);
      push_load(9'd511, 8'hFF);
      push_load(9'd0, 8'h00);
      init_txn(1, 1'b0);
      raw_txn(6'd0, 32'd0, 1'b0, 8'h01);
      raw_txn(6'd63, 32'hFFFF_FFFF, 1'b1, 8'h00);
      push_op(OP_RAW);
      push_op(OP_READ);
      push_load(9'd5, 8'h5A);
      repeat (14) push_rx(8'hFF);
      push_rx(8'hFF);
      read_txn(0);
      read_txn(1);
      read_txn(2);
      write_txn(1'b1, 8'hE5);
      write_txn(1'b0, 8'hE5);
      write_txn(1'b1, 8'h0B);
      write_txn(1'b1, 8'h0D);
      write_txn(1'b1, 8'h1F);
      write_txn(1'b1, 8'h04);
      write_txn(1'b1, 8'h07);
      settle_idle();
      init_txn(0, 1'b1);
      read_txn(0);
      settle_idle();

      for (int ph = 0; ph <= 4; ph++) begin
         if (ph > 0) write_limit(limits[ph-1]);
         target = req_taken + stim_q.size() + 210;
         while (req_taken + stim_q.size() < target) begin
            random_op();
            while (stim_q.size() > 40) @(posedge clock);
         end
         settle_idle();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
